>>> rtl/rgb_hsl_color_classifier_top_defines.svh
// ============================================================================
// RGB to HSL color classifier - assertion macros
// Concurrent checks clocked on clk and disabled while rst_n is low.
// ============================================================================
`ifndef RGB_HSL_COLOR_CLASSIFIER_TOP_DEFINES_SVH
`define RGB_HSL_COLOR_CLASSIFIER_TOP_DEFINES_SVH

// Same-cycle implication
`define RHC_ASSERT_SAME(label, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
        else $error(msg);

// Next-cycle implication
`define RHC_ASSERT_NEXT(label, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error(msg);

`endif

>>> rtl/rhc_pkg.sv
// ============================================================================
// RGB to HSL color classifier - package
// Field widths, class codes and fixed thresholds of the classifier.
// ============================================================================
package rhc_pkg;

    // field widths
    localparam int CH_W   = 8;
    localparam int CLS_W  = 4;
    localparam int HUE_W  = 15;
    localparam int PCT_W  = 13;

    // internal widths: hue sector numerator over 60, its 60x, and d*100
    localparam int K_W    = 11;
    localparam int HNUM_W = 17;
    localparam int PNUM_W = 15;

    // color class codes
    localparam logic [CLS_W-1:0] CLS_BLACK   = 4'd0;
    localparam logic [CLS_W-1:0] CLS_WHITE   = 4'd1;
    localparam logic [CLS_W-1:0] CLS_GRAY    = 4'd2;
    localparam logic [CLS_W-1:0] CLS_RED     = 4'd3;
    localparam logic [CLS_W-1:0] CLS_YELLOW  = 4'd4;
    localparam logic [CLS_W-1:0] CLS_GREEN   = 4'd5;
    localparam logic [CLS_W-1:0] CLS_CYAN    = 4'd6;
    localparam logic [CLS_W-1:0] CLS_BLUE    = 4'd7;
    localparam logic [CLS_W-1:0] CLS_MAGENTA = 4'd8;

    // lightness 20% and 80% expressed on s = max + min (s / 5.1)
    localparam logic [CH_W:0] S_BLACK_LIM = 9'd102;
    localparam logic [CH_W:0] S_WHITE_LIM = 9'd408;

endpackage

>>> rtl/rhc_divider.sv
// ============================================================================
// RHC pipelined divider
// Restoring division, one quotient bit per register stage. The caller
// guarantees num < den * 2^QUO_W, so only QUO_W steps are needed.
// ============================================================================
module rhc_divider #(
    parameter int NUM_W = 23,
    parameter int DEN_W = 8,
    parameter int QUO_W = 15
) (
    input  logic             clk,
    input  logic [QUO_W:0]   adv,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [QUO_W-1:0] quo
);

    localparam int HI_W = NUM_W - QUO_W;

    logic [DEN_W-1:0] rem_reg  [0:QUO_W];
    logic [QUO_W-1:0] work_reg [0:QUO_W];
    logic [DEN_W-1:0] den_reg  [0:QUO_W];

    // initial partial remainder: dividend bits above the quotient field
    logic [HI_W+DEN_W-1:0] hi_ext;
    assign hi_ext = {{DEN_W{1'b0}}, num[NUM_W-1:QUO_W]};

    // load stage
    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            rem_reg[0]  <= hi_ext[DEN_W-1:0];
            work_reg[0] <= num[QUO_W-1:0];
            den_reg[0]  <= den;
        end
    end

    // one compare/subtract per stage; quotient bits shift into work
    for (genvar j = 1; j <= QUO_W; j++)
    begin : g_step
        logic [DEN_W:0]   trial;
        logic             ge;
        logic [DEN_W:0]   diff;
        logic [DEN_W-1:0] rem_next;
        logic [QUO_W-1:0] work_next;

        always_comb
        begin
            trial     = {rem_reg[j-1], work_reg[j-1][QUO_W-1]};
            diff      = trial - {1'b0, den_reg[j-1]};
            ge        = (trial >= {1'b0, den_reg[j-1]});
            rem_next  = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            work_next = {work_reg[j-1][QUO_W-2:0], ge};
        end

        always_ff @(posedge clk)
        begin
            if (adv[j])
            begin
                rem_reg[j]  <= rem_next;
                work_reg[j] <= work_next;
                den_reg[j]  <= den_reg[j-1];
            end
        end
    end

    assign quo = work_reg[QUO_W];

endmodule

>>> rtl/rgb_hsl_color_classifier_top.sv
// ============================================================================
// RGB to HSL color classifier - top level
// Converts an 8-bit RGB pixel to fixed-point HSL and a nine-way color class.
// ============================================================================
// One pixel per clock sustained while out_stall is low. The path holds
// FRAC_BITS + 13 register stages between the edge that accepts an input
// transaction and the output registers that take its result, in order: an input
// register, one stage that sorts the channels, one stage that classifies and
// loads the dividers, FRAC_BITS + 9 divider stages (hue and saturation each
// come from a restoring divider that settles one quotient bit per stage;
// lightness is a reciprocal multiply in the classify stage, delayed alongside),
// and the output register. The pipeline closes bubbles, so in_stall rises
// only when every stage holds a pixel and out_stall is high.
module rgb_hsl_color_classifier_top #(
    parameter int FRAC_BITS = 6
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [rhc_pkg::CH_W-1:0]    red,
    input  logic [rhc_pkg::CH_W-1:0]    green,
    input  logic [rhc_pkg::CH_W-1:0]    blue,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [rhc_pkg::CLS_W-1:0]   color_class,
    output logic [rhc_pkg::HUE_W-1:0]   hue,
    output logic [rhc_pkg::PCT_W-1:0]   saturation,
    output logic [rhc_pkg::PCT_W-1:0]   lightness
);

    import rhc_pkg::*;

`include "rgb_hsl_color_classifier_top_defines.svh"

    // quotient bits: hue below 512 * 2^F, percentages below 128 * 2^F
    localparam int QW     = 9 + FRAC_BITS;
    localparam int HNUM_N = HNUM_W + FRAC_BITS;
    localparam int PNUM_N = PNUM_W + FRAC_BITS;
    localparam int NS     = QW + 4;
    localparam int BLACK_LGT = 20 << FRAC_BITS;
    // lightness reciprocal: ceil(50 * 2^(F+17) / 255), 17 bits keep s <= 510 exact
    localparam longint LGT_M  = ((longint'(50) << (FRAC_BITS + 17)) + 254) / 255;
    localparam int     LGT_PW = QW + 17;

    // ------------------------------------------------------------------
    // stage occupancy and flow control
    // ------------------------------------------------------------------
    logic [NS-1:0] v_reg;
    logic [NS:0]   ready;

    assign ready[NS] = !out_stall;
    for (genvar i = 0; i < NS; i++)
    begin : g_ready
        assign ready[i] = !v_reg[i] || ready[i+1];
    end

    assign in_stall  = !ready[0];
    assign out_valid = v_reg[NS-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (ready[0])
            begin
                v_reg[0] <= in_valid;
            end
            for (int i = 1; i < NS; i++)
            begin
                if (ready[i])
                begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 0: input register
    // ------------------------------------------------------------------
    logic [CH_W-1:0] red_reg, green_reg, blue_reg;

    always_ff @(posedge clk)
    begin
        if (ready[0])
        begin
            red_reg   <= red;
            green_reg <= green;
            blue_reg  <= blue;
        end
    end

    // ------------------------------------------------------------------
    // stage 1: max/min, chroma, sum, saturation divisor, hue numerator / 60
    // ------------------------------------------------------------------
    logic            r_max, g_max;
    logic [CH_W-1:0] mx, mn;
    logic [CH_W-1:0] d_next;
    logic [CH_W:0]   s_next;
    logic [CH_W:0]   den_full;
    logic [CH_W-1:0] den_next;
    logic [11:0]     k_full;
    logic [11:0]     r12, g12, b12, d12;

    always_comb
    begin
        r_max    = (red_reg >= green_reg) && (red_reg >= blue_reg);
        g_max    = !r_max && (green_reg >= blue_reg);
        mx       = r_max ? red_reg : (g_max ? green_reg : blue_reg);
        mn       = red_reg;
        if (green_reg < mn)
        begin
            mn = green_reg;
        end
        if (blue_reg < mn)
        begin
            mn = blue_reg;
        end
        d_next   = mx - mn;
        s_next   = {1'b0, mx} + {1'b0, mn};
        den_full = (s_next < 9'd255) ? s_next : (9'd510 - s_next);
        den_next = den_full[CH_W-1:0];
        r12      = {4'b0, red_reg};
        g12      = {4'b0, green_reg};
        b12      = {4'b0, blue_reg};
        d12      = {4'b0, d_next};
        // hue numerator is 60 * k; intermediate wrap is fine, k ends >= 0
        if (r_max)
        begin
            k_full = (green_reg >= blue_reg) ? (g12 - b12) : (12'd6 * d12 + g12 - b12);
        end
        else if (g_max)
        begin
            k_full = 12'd2 * d12 + b12 - r12;
        end
        else
        begin
            k_full = 12'd4 * d12 + r12 - g12;
        end
    end

    logic [CH_W-1:0] d_reg, den_reg;
    logic [CH_W:0]   s_reg;
    logic [K_W-1:0]  k_reg;

    always_ff @(posedge clk)
    begin
        if (ready[1])
        begin
            d_reg   <= d_next;
            s_reg   <= s_next;
            den_reg <= den_next;
            k_reg   <= k_full[K_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // stage 2: class decision and divider operands
    // ------------------------------------------------------------------
    logic [CLS_W-1:0]  cls_next;
    logic [11:0]       k2, dd;
    logic [HNUM_W-1:0] hnum;
    logic [PNUM_W-1:0] d100;
    logic [HNUM_N-1:0] hue_num;
    logic [PNUM_N-1:0] sat_num;
    logic [LGT_PW-1:0] lgt_prod;

    always_comb
    begin
        k2 = {k_reg, 1'b0};
        dd = {4'b0, d_reg};
        if (s_reg < S_BLACK_LIM)
        begin
            cls_next = CLS_BLACK;
        end
        else if (s_reg > S_WHITE_LIM)
        begin
            cls_next = CLS_WHITE;
        end
        else if ((d_reg == '0) || ({d_reg, 2'b0} < {2'b0, den_reg}))
        begin
            cls_next = CLS_GRAY;
        end
        // sector edges at 30 + 60n degrees: 2k against odd multiples of d
        else if (k2 < dd)
        begin
            cls_next = CLS_RED;
        end
        else if (k2 < 12'd3 * dd)
        begin
            cls_next = CLS_YELLOW;
        end
        else if (k2 < 12'd5 * dd)
        begin
            cls_next = CLS_GREEN;
        end
        else if (k2 < 12'd7 * dd)
        begin
            cls_next = CLS_CYAN;
        end
        else if (k2 < 12'd9 * dd)
        begin
            cls_next = CLS_BLUE;
        end
        else if (k2 < 12'd11 * dd)
        begin
            cls_next = CLS_MAGENTA;
        end
        else
        begin
            cls_next = CLS_RED;
        end
    end

    assign hnum    = HNUM_W'(k_reg) * HNUM_W'(60);
    assign d100    = PNUM_W'(d_reg) * PNUM_W'(100);
    assign hue_num = HNUM_N'(hnum) << FRAC_BITS;
    assign sat_num = PNUM_N'(d100) << FRAC_BITS;

    // lightness: s * 100 / 510 = s * 50 / 255, by reciprocal multiply
    assign lgt_prod = LGT_PW'(s_reg) * LGT_PW'(LGT_M);

    // ------------------------------------------------------------------
    // dividers, stages 2 .. QW+2
    // ------------------------------------------------------------------
    logic [QW-1:0] hue_q, sat_q, lgt_q;

    rhc_divider #(
        .NUM_W (HNUM_N),
        .DEN_W (CH_W),
        .QUO_W (QW)
    ) u_hue_div (
        .clk (clk),
        .adv (ready[QW+2:2]),
        .num (hue_num),
        .den (d_reg),
        .quo (hue_q)
    );

    rhc_divider #(
        .NUM_W (PNUM_N),
        .DEN_W (CH_W),
        .QUO_W (QW)
    ) u_sat_div (
        .clk (clk),
        .adv (ready[QW+2:2]),
        .num (sat_num),
        .den (den_reg),
        .quo (sat_q)
    );

    // class, achromatic flag and lightness ride alongside the divider stages
    logic [CLS_W-1:0] cls_reg     [0:QW];
    logic             dz_reg      [0:QW];
    logic [QW-1:0]    lgt_dly_reg [0:QW];

    always_ff @(posedge clk)
    begin
        if (ready[2])
        begin
            cls_reg[0]     <= cls_next;
            dz_reg[0]      <= (d_reg == '0);
            lgt_dly_reg[0] <= lgt_prod[LGT_PW-1:17];
        end
        for (int j = 1; j <= QW; j++)
        begin
            if (ready[2+j])
            begin
                cls_reg[j]     <= cls_reg[j-1];
                dz_reg[j]      <= dz_reg[j-1];
                lgt_dly_reg[j] <= lgt_dly_reg[j-1];
            end
        end
    end

    assign lgt_q = lgt_dly_reg[QW];

    // ------------------------------------------------------------------
    // output register: fields masked to their port widths
    // ------------------------------------------------------------------
    logic [QW+HUE_W-1:0] hue_ext;
    logic [QW+PCT_W-1:0] sat_ext, lgt_ext;
    logic [CLS_W-1:0]    cls_out_reg;
    logic [HUE_W-1:0]    hue_reg;
    logic [PCT_W-1:0]    sat_reg, lgt_reg;

    assign hue_ext = {{HUE_W{1'b0}}, hue_q};
    assign sat_ext = {{PCT_W{1'b0}}, sat_q};
    assign lgt_ext = {{PCT_W{1'b0}}, lgt_q};

    always_ff @(posedge clk)
    begin
        if (ready[NS-1])
        begin
            cls_out_reg <= cls_reg[QW];
            hue_reg     <= dz_reg[QW] ? '0 : hue_ext[HUE_W-1:0];
            sat_reg     <= dz_reg[QW] ? '0 : sat_ext[PCT_W-1:0];
            lgt_reg     <= lgt_ext[PCT_W-1:0];
        end
    end

    assign color_class = cls_out_reg;
    assign hue         = hue_reg;
    assign saturation  = sat_reg;
    assign lightness   = lgt_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `RHC_ASSERT_SAME(a_stall_only_full, in_stall, out_valid && out_stall && (&v_reg), "input stalled while pipeline has room")
    `RHC_ASSERT_NEXT(a_accept_loads, in_valid && !in_stall, v_reg[0] && (red_reg == $past(red)) && (blue_reg == $past(blue)), "accepted pixel not captured")
    `RHC_ASSERT_SAME(a_black_dark, out_valid && (color_class == CLS_BLACK), lightness < BLACK_LGT, "black class with lightness at or above 20%")
    `RHC_ASSERT_SAME(a_class_range, out_valid, color_class <= CLS_MAGENTA, "class code out of range")

endmodule
